### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and codes for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 4096;
  localparam int unsigned SCAN_WIDTH_DEF = 64;

  localparam int unsigned BLK_W      = 12;
  localparam int unsigned LIM_W      = 13;
  localparam int unsigned FIELD_SPAN = 4096;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [LIM_W-1:0] TOTAL_RST = 13'd4096;
  localparam logic [BLK_W-1:0] FDB_RST   = 12'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_BLOCKS     = 2'd0,
    CFG_FIRST_DATA_BLOCK = 2'd1
  } cfg_idx_e;

endpackage

### rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bba_word_chk.sv
// ----------------------------------------------------------------------------
// bba_word_chk
// Scan unit: masks one map row to the allocatable window and finds the
// lowest free bit in it.
// ----------------------------------------------------------------------------
module bba_word_chk #(
  parameter int unsigned W     = 64,
  parameter int unsigned CW    = 13,
  parameter int unsigned LOG2W = $clog2(W)
) (
  input  logic [W-1:0]     word_i,
  input  logic [CW-1:0]    row_i,
  input  logic [CW-1:0]    first_row_i,
  input  logic [LOG2W-1:0] lo_sh_i,
  input  logic [CW-1:0]    last_row_i,
  input  logic [LOG2W-1:0] hi_sh_i,
  output logic             hit_o,
  output logic [LOG2W-1:0] idx_o
);

  logic [W-1:0] ones;
  logic [W-1:0] lo_mask;
  logic [W-1:0] hi_mask;
  logic [W-1:0] cand;

  assign ones = '1;

  always_comb begin
    if (row_i > first_row_i) begin
      lo_mask = ones;
    end else if (row_i == first_row_i) begin
      lo_mask = ones << lo_sh_i;
    end else begin
      lo_mask = '0;
    end
    if (row_i < last_row_i) begin
      hi_mask = ones;
    end else if (row_i == last_row_i) begin
      hi_mask = ~((ones << hi_sh_i) << 1);
    end else begin
      hi_mask = '0;
    end
  end

  assign cand  = ~word_i & lo_mask & hi_mask;
  assign hit_o = |cand;

  // lowest set bit wins
  always_comb begin
    idx_o = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx_o = LOG2W'(i);
      end
    end
  end

endmodule

### rtl/bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit block allocator over a one-bit-per-block in-use map.
// ----------------------------------------------------------------------------
//  channel | handshake                  | word
//  in      | in_valid_i / in_stall_o    | kind_i, block_number_i
//  out     | out_valid_o / out_stall_i  | status_o, result_block_o
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  Map is held in RAM rows of SCAN_WIDTH bits; one row is read per cycle.
//  Allocate: rows are read from the first data block's row up to the row
//  that holds the hit or the last allocatable row.
//  Free: read, check and write back the row; an out-of-range free is rejected at once.
//  Reset clears the map at once through per-row valid flops; no sweep.
//  A held result word delays only the finishing step of the next request.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SCAN_WIDTH = bba_pkg::SCAN_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [bba_pkg::BLK_W-1:0]       block_number_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [bba_pkg::BLK_W-1:0]       result_block_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned NW    = MAX_BLOCKS / SCAN_WIDTH;
  localparam int unsigned WAW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned LOG2W = $clog2(SCAN_WIDTH);
  localparam int unsigned LW    = bba_pkg::LIM_W;
  localparam int unsigned BW    = bba_pkg::BLK_W;
  localparam int unsigned CW    = (WAW > LW) ? WAW : LW;
  localparam logic [LW-1:0] MAX_LIM = (MAX_BLOCKS < bba_pkg::FIELD_SPAN) ?
                                      LW'(MAX_BLOCKS) : LW'(bba_pkg::FIELD_SPAN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FRD,
    S_FCHK,
    S_FAIL
  } state_e;

  state_e                   state_q, state_d;
  logic [LW-1:0]            total_q, total_d;
  logic [BW-1:0]            fdb_q, fdb_d;
  logic [CW-1:0]            rd_q, rd_d;
  logic [CW-1:0]            chk_q, chk_d;
  logic                     chk_vld_q, chk_vld_d;
  logic                     kind_q, kind_d;
  logic [BW-1:0]            blk_q, blk_d;
  logic [NW-1:0]            row_vld_q, row_vld_d;
  logic                     out_vld_q, out_vld_d;
  bba_pkg::status_e         status_q, status_d;
  logic [BW-1:0]            result_q, result_d;

  logic [LW-1:0]            lim;
  logic [LW-1:0]            lim_m1;
  logic                     alloc_empty;
  logic                     free_bad;
  logic [CW-1:0]            first_row;
  logic [CW-1:0]            last_row;
  logic [CW-1:0]            blk_row;
  logic [CW-1:0]            in_row;
  logic                     in_acc;
  logic                     out_free;

  logic                     ram_we;
  logic                     ram_re;
  logic [WAW-1:0]           ram_waddr;
  logic [WAW-1:0]           ram_raddr;
  logic [SCAN_WIDTH-1:0]    ram_wdata;
  logic [SCAN_WIDTH-1:0]    ram_rdata;
  logic [SCAN_WIDTH-1:0]    row_data;
  logic                     hit;
  logic [LOG2W-1:0]         hit_idx;
  logic [CW+LOG2W-1:0]      found_blk;
  logic [SCAN_WIDTH-1:0]    bit_sel;

  assign lim         = (total_q < MAX_LIM) ? total_q : MAX_LIM;
  assign lim_m1      = lim - LW'(1);
  assign alloc_empty = ({1'b0, fdb_q} >= lim);
  assign first_row   = CW'(fdb_q >> LOG2W);
  assign last_row    = CW'(lim_m1 >> LOG2W);
  assign blk_row     = CW'(blk_q >> LOG2W);
  assign in_row      = CW'(block_number_i >> LOG2W);
  assign free_bad    = (block_number_i < fdb_q) || ({1'b0, block_number_i} >= lim);

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || !out_stall_i;

  assign ram_waddr = chk_q[WAW-1:0];
  assign row_data  = row_vld_q[chk_q[WAW-1:0]] ? ram_rdata : '0;
  assign found_blk = {chk_q, hit_idx};
  assign bit_sel   = SCAN_WIDTH'(1) << blk_q[LOG2W-1:0];

  bba_ram #(
    .WIDTH (SCAN_WIDTH),
    .DEPTH (NW),
    .AW    (WAW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bba_word_chk #(
    .W     (SCAN_WIDTH),
    .CW    (CW),
    .LOG2W (LOG2W)
  ) u_chk (
    .word_i      (row_data),
    .row_i       (chk_q),
    .first_row_i (first_row),
    .lo_sh_i     (fdb_q[LOG2W-1:0]),
    .last_row_i  (last_row),
    .hi_sh_i     (lim_m1[LOG2W-1:0]),
    .hit_o       (hit),
    .idx_o       (hit_idx)
  );

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    fdb_d     = fdb_q;
    rd_d      = rd_q;
    chk_d     = chk_q;
    chk_vld_d = chk_vld_q;
    kind_d    = kind_q;
    blk_d     = blk_q;
    row_vld_d = row_vld_q;
    out_vld_d = out_vld_q && out_stall_i;
    status_d  = status_q;
    result_d  = result_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rd_q[WAW-1:0];
    ram_wdata = row_data;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bba_pkg::CFG_TOTAL_BLOCKS:     total_d = cfg_data_i[LW-1:0];
        bba_pkg::CFG_FIRST_DATA_BLOCK: fdb_d   = cfg_data_i[BW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d    = kind_i;
          blk_d     = block_number_i;
          chk_vld_d = 1'b0;
          if (kind_i == bba_pkg::KIND_ALLOC) begin
            if (alloc_empty) begin
              state_d = S_FAIL;
            end else begin
              rd_d    = first_row;
              state_d = S_SCAN;
            end
          end else begin
            if (free_bad) begin
              state_d = S_FAIL;
            end else begin
              chk_d   = in_row;
              state_d = S_FRD;
            end
          end
        end
      end
      S_SCAN: begin
        if (chk_vld_q && hit) begin
          if (out_free) begin
            ram_we    = 1'b1;
            ram_wdata = row_data | (SCAN_WIDTH'(1) << hit_idx);
            row_vld_d[ram_waddr] = 1'b1;
            status_d  = bba_pkg::ST_OK;
            result_d  = found_blk[BW-1:0];
            chk_vld_d = 1'b0;
            out_vld_d = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (chk_vld_q && (chk_q == last_row)) begin
          if (out_free) begin
            status_d  = bba_pkg::ST_FULL;
            result_d  = '0;
            chk_vld_d = 1'b0;
            out_vld_d = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (rd_q <= last_row) begin
          ram_re    = 1'b1;
          chk_d     = rd_q;
          chk_vld_d = 1'b1;
          rd_d      = rd_q + CW'(1);
        end else begin
          chk_vld_d = 1'b0;
        end
      end
      S_FRD: begin
        ram_re    = 1'b1;
        ram_raddr = blk_row[WAW-1:0];
        state_d   = S_FCHK;
      end
      S_FCHK: begin
        if (out_free) begin
          if (|(row_data & bit_sel)) begin
            ram_we    = 1'b1;
            ram_wdata = row_data & ~bit_sel;
            row_vld_d[ram_waddr] = 1'b1;
            status_d  = bba_pkg::ST_OK;
          end else begin
            status_d  = bba_pkg::ST_BAD_FREE;
          end
          result_d  = '0;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_FAIL: begin
        if (out_free) begin
          if (kind_q == bba_pkg::KIND_ALLOC) begin
            status_d = bba_pkg::ST_FULL;
          end else begin
            status_d = bba_pkg::ST_BAD_FREE;
          end
          result_d  = '0;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= bba_pkg::TOTAL_RST;
      fdb_q     <= bba_pkg::FDB_RST;
      chk_vld_q <= 1'b0;
      row_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      fdb_q     <= fdb_d;
      chk_vld_q <= chk_vld_d;
      row_vld_q <= row_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q     <= rd_d;
    chk_q    <= chk_d;
    kind_q   <= kind_d;
    blk_q    <= blk_d;
    status_q <= status_d;
    result_q <= result_d;
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign result_block_o = result_q;

`ifndef NO_ASSERTIONS
  a_alloc_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (status_q == bba_pkg::ST_OK) && (result_q != '0) |->
      (result_q >= fdb_q) && ({1'b0, result_q} < lim))
    else $error("allocated block outside window");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (status_q != bba_pkg::ST_OK) |-> (result_q == '0))
    else $error("failed request with nonzero block");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted word did not start work");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SCAN) || (state_q == S_FCHK))
    else $error("map written outside scan or free check");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(status_q) && $stable(result_q))
    else $error("stalled result word changed");
`endif

endmodule

### bench/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Watches the request, result and register channels of the bitmap block
// allocator. It keeps its own in-use map and geometry, works out the answer
// to every accepted request, and compares each accepted result word in order.
// ----------------------------------------------------------------------------
module bba_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           kind_i,
  input  logic [bba_pkg::BLK_W-1:0]      block_number_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [1:0]                     status_i,
  input  logic [bba_pkg::BLK_W-1:0]      result_block_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             grants_o,
  output int                             full_o,
  output int                             freed_o,
  output int                             rejected_o
);

  typedef struct packed {
    bba_pkg::kind_e            kind;
    bba_pkg::status_e          status;
    logic [bba_pkg::BLK_W-1:0] block;
  } answer_t;

  logic [bba_pkg::MAX_BLOCKS_DEF-1:0] used_map;
  logic [bba_pkg::LIM_W-1:0]          total_q;
  logic [bba_pkg::BLK_W-1:0]          fdb_q;
  answer_t                            answers_q[$];
  int                                 words_in;
  int                                 words_out;

  assign pending_o = words_in - words_out;

  // First-fit allocate or checked free against the shadow map.
  task automatic serve_request(input bba_pkg::kind_e k,
                               input logic [bba_pkg::BLK_W-1:0] blk,
                               output answer_t ans);
    int unsigned lim;
    int unsigned b;
    bit          hit;
    lim = 32'(total_q);
    if (lim > bba_pkg::MAX_BLOCKS_DEF) lim = bba_pkg::MAX_BLOCKS_DEF;
    if (lim > bba_pkg::FIELD_SPAN) lim = bba_pkg::FIELD_SPAN;
    ans.kind   = k;
    ans.status = bba_pkg::ST_BAD_FREE;
    ans.block  = '0;
    hit        = 1'b0;
    if (k == bba_pkg::KIND_ALLOC) begin
      ans.status = bba_pkg::ST_FULL;
      for (b = 32'(fdb_q); b < lim && !hit; b++) begin
        if (!used_map[b[bba_pkg::BLK_W-1:0]]) begin
          used_map[b[bba_pkg::BLK_W-1:0]] = 1'b1;
          ans.status  = bba_pkg::ST_OK;
          ans.block   = b[bba_pkg::BLK_W-1:0];
          hit         = 1'b1;
        end
      end
    end else if (blk >= fdb_q && blk < lim && used_map[blk]) begin
      used_map[blk] = 1'b0;
      ans.status    = bba_pkg::ST_OK;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    answer_t got;
    if (!rst_ni) begin
      used_map = '0;
      total_q  = bba_pkg::TOTAL_RST;
      fdb_q    = bba_pkg::FDB_RST;
      answers_q.delete();
      words_in     <= 0;
      words_out    <= 0;
      fail_count_o <= 0;
      grants_o     <= 0;
      full_o       <= 0;
      freed_o      <= 0;
      rejected_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bba_pkg::CFG_TOTAL_BLOCKS:     total_q = cfg_data_i;
          bba_pkg::CFG_FIRST_DATA_BLOCK: fdb_q   = cfg_data_i[bba_pkg::BLK_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        words_out <= words_out + 1;
        if (answers_q.size() == 0) begin
          $display("%0t: result word with none pending: status %0d block %0d",
                   $time, status_i, result_block_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answers_q.pop_front();
          if (status_i !== want.status || result_block_i !== want.block) begin
            if (status_i !== want.status)
              $display("%0t: status mismatch (%s), expected %0d actual %0d",
                       $time, want.kind.name(), want.status, status_i);
            if (result_block_i !== want.block)
              $display("%0t: result_block mismatch (%s), expected %0d actual %0d",
                       $time, want.kind.name(), want.block, result_block_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        serve_request(bba_pkg::kind_e'(kind_i), block_number_i, got);
        answers_q.push_back(got);
        words_in <= words_in + 1;
        if (got.kind == bba_pkg::KIND_ALLOC) begin
          if (got.status == bba_pkg::ST_OK) grants_o <= grants_o + 1;
          else full_o <= full_o + 1;
        end else begin
          if (got.status == bba_pkg::ST_OK) freed_o <= freed_o + 1;
          else rejected_o <= rejected_o + 1;
        end
      end
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bitmap block allocator. Directed requests hit
// reserved blocks, double frees, out-of-range frees, an empty disk and the
// field extremes; then random phases of allocate/free traffic run over many
// disk geometries, mostly small ones so the map fills up. Requests come in
// bursts, results are stalled on a pattern of their own, and bba_checker
// compares every result word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 100;
  localparam int BW           = bba_pkg::BLK_W;

  logic                           clk_i;
  logic                           rst_ni         = 1'b0;
  logic                           in_valid_i     = 1'b0;
  logic                           in_stall_o;
  logic                           kind_i         = 1'b0;
  logic [bba_pkg::BLK_W-1:0]      block_number_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i    = 1'b0;
  logic [1:0]                     status_o;
  logic [bba_pkg::BLK_W-1:0]      result_block_o;
  logic                           cfg_valid_i    = 1'b0;
  logic                           cfg_ready_o;
  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data_i     = '0;

  int fail_count;
  int pending;
  int grants;
  int full_cnt;
  int freed;
  int rejected;

  int cycles     = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int cur_total  = int'(bba_pkg::TOTAL_RST);
  int cur_fdb    = int'(bba_pkg::FDB_RST);
  int phases     = 0;

  bitmap_block_allocator_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_block_o (result_block_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  bba_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .block_number_i (block_number_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .result_block_i (result_block_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .grants_o       (grants),
    .full_o         (full_cnt),
    .freed_o        (freed),
    .rejected_o     (rejected)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result stall: free-flowing, light, heavy and toggling stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(10, 80);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 99) < 30);
        2: out_stall_i <= ($urandom_range(0, 99) < 75);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  task automatic send_req(input bba_pkg::kind_e k, input logic [bba_pkg::BLK_W-1:0] blk);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left     = burst_left - 1;
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    block_number_i <= blk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending > 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input bba_pkg::cfg_idx_e idx,
                           input logic [bba_pkg::CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == bba_pkg::CFG_TOTAL_BLOCKS) cur_total = int'(data);
    if (idx == bba_pkg::CFG_FIRST_DATA_BLOCK) cur_fdb = int'(data[bba_pkg::BLK_W-1:0]);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_geometry(input logic [bba_pkg::CFG_DATA_W-1:0] total,
                              input logic [bba_pkg::CFG_DATA_W-1:0] fdb);
    wait_idle();
    cfg_write(bba_pkg::CFG_TOTAL_BLOCKS, total, 1'b0);
    cfg_write(bba_pkg::CFG_FIRST_DATA_BLOCK, fdb, 1'b1);
    phases++;
  endtask

  task automatic send_random();
    int r;
    int lim;
    int lo;
    int hi;
    r   = $urandom_range(0, 99);
    lim = (cur_total > bba_pkg::FIELD_SPAN) ? bba_pkg::FIELD_SPAN : cur_total;
    lo  = (cur_fdb > 0) ? cur_fdb - 1 : 0;
    hi  = (lim + 1 > bba_pkg::FIELD_SPAN - 1) ? bba_pkg::FIELD_SPAN - 1 : lim + 1;
    if (r < 50) send_req(bba_pkg::KIND_ALLOC, BW'($urandom()));
    else if (r < 90) send_req(bba_pkg::KIND_FREE, BW'($urandom_range(lo, hi)));
    else send_req(bba_pkg::KIND_FREE, BW'($urandom()));
  endtask

  initial begin
    int sent;
    int n;
    int c;
    int t;
    int f;
    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: block 0 reserved
    send_req(bba_pkg::KIND_ALLOC, 12'hFFF);
    send_req(bba_pkg::KIND_ALLOC, 12'h000);
    send_req(bba_pkg::KIND_FREE, 12'd1);
    send_req(bba_pkg::KIND_FREE, 12'd1);
    send_req(bba_pkg::KIND_FREE, 12'd0);
    send_req(bba_pkg::KIND_FREE, 12'hFFF);
    send_req(bba_pkg::KIND_ALLOC, 12'h555);

    // unknown indexes, then a three-block disk that is already full
    wait_idle();
    cfg_write(bba_pkg::cfg_idx_e'(2'd2), 13'h1FFF, 1'b0);
    cfg_write(bba_pkg::cfg_idx_e'(2'd3), 13'h0AAA, 1'b0);
    cfg_write(bba_pkg::CFG_TOTAL_BLOCKS, 13'd3, 1'b0);
    cfg_write(bba_pkg::CFG_FIRST_DATA_BLOCK, 13'd1, 1'b1);
    phases++;
    send_req(bba_pkg::KIND_ALLOC, 12'hAAA);
    send_req(bba_pkg::KIND_FREE, 12'd3);
    send_req(bba_pkg::KIND_FREE, 12'd2);
    send_req(bba_pkg::KIND_ALLOC, 12'h000);

    // empty disk
    wait_idle();
    cfg_write(bba_pkg::CFG_TOTAL_BLOCKS, 13'd0, 1'b1);
    phases++;
    send_req(bba_pkg::KIND_ALLOC, 12'h000);
    send_req(bba_pkg::KIND_FREE, 12'd1);

    // total beyond the field span, everything but the top block reserved
    set_geometry(13'h1FFF, 13'h1FFF);
    send_req(bba_pkg::KIND_ALLOC, 12'h000);
    send_req(bba_pkg::KIND_ALLOC, 12'hFFF);
    send_req(bba_pkg::KIND_FREE, 12'd4094);
    send_req(bba_pkg::KIND_FREE, 12'd4095);
    send_req(bba_pkg::KIND_ALLOC, 12'h123);

    // nothing reserved
    set_geometry(13'd4096, 13'd0);
    send_req(bba_pkg::KIND_ALLOC, 12'hFFF);
    send_req(bba_pkg::KIND_FREE, 12'd0);
    send_req(bba_pkg::KIND_FREE, 12'd2);
    send_req(bba_pkg::KIND_FREE, 12'd1);

    while (sent < RANDOM_ITEMS) begin
      c = $urandom_range(0, 9);
      if (c <= 5) begin
        t = $urandom_range(1, 96);
        f = $urandom_range(0, 6);
      end else if (c == 6) begin
        t = bba_pkg::FIELD_SPAN;
        f = $urandom_range(0, bba_pkg::FIELD_SPAN - 1);
      end else if (c == 7) begin
        t = $urandom_range(97, bba_pkg::FIELD_SPAN);
        f = $urandom_range(0, 64);
      end else if (c == 8) begin
        t = $urandom_range(0, 8191);
        f = $urandom_range(0, 8191);
      end else begin
        t = $urandom_range(1, 40);
        f = t + $urandom_range(0, 3);
      end
      set_geometry(t[bba_pkg::CFG_DATA_W-1:0], f[bba_pkg::CFG_DATA_W-1:0]);
      n = $urandom_range(15, 60);
      repeat (n) begin
        send_random();
        sent++;
        if ($urandom_range(0, 99) < 3) wait_idle();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d register settings, %0d allocations granted, %0d out of space",
             phases, grants, full_cnt);
    $display("%0d frees done, %0d frees refused, %0d cycles", freed, rejected, cycles);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### bitmap_block_allocator_top.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_word_chk.sv
rtl/bitmap_block_allocator_top.sv
bench/bba_checker.sv
bench/testbench.sv
